### hdl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants, stage map and pipeline record of the converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int ROOT_BITS = 16;

  localparam int ANG_PI      = 25736;
  localparam int ANG_HALF_PI = 12868;
  localparam int K028_Q16    = 18350;
  localparam int ONE_Q16     = 65536;

  localparam int ZQ_BITS  = 32;
  localparam int ZZ_BITS  = 47;
  localparam int Q2_BITS  = 14;
  localparam int NUM_BITS = 45;

  // stage map
  localparam int ST_ABS   = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_DIV1  = 2;
  localparam int ST_SQR   = ST_DIV1 + ZQ_BITS;
  localparam int ST_K     = ST_SQR + 1;
  localparam int ST_SETUP = ST_K + 1;
  localparam int ST_DIV2  = ST_SETUP + 1;
  localparam int ST_OUT   = ST_DIV2 + Q2_BITS;
  localparam int NSTAGES  = ST_OUT + 1;

  typedef struct packed {
    logic [15:0]           ax;
    logic [15:0]           ay;
    logic                  xneg;
    logic                  yneg;
    logic                  xzero;
    logic                  yzero;
    logic                  ratio_lt;
    logic [30:0]           xx;
    logic [30:0]           yy;
    logic [31:0]           sq;
    logic [ROOT_BITS-1:0]  rt;
    logic [31:0]           r1;
    logic [ZQ_BITS-1:0]    q1;
    logic [ZZ_BITS-1:0]    zz;
    logic [14:0]           k;
    logic [NUM_BITS-1:0]   r2;
    logic [ZZ_BITS-1:0]    d2;
    logic [Q2_BITS-1:0]    q2;
    logic signed [15:0]    ang;
    logic [15:0]           mag;
  } pipe_t;

endpackage

### hdl/cpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_in_if / cpc_out_if
// Valid/ready channels for cartesian vectors and polar results.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_comp;
  logic signed [15:0] y_comp;

  modport source (output valid, output x_comp, output y_comp, input ready);
  modport sink   (input valid, input x_comp, input y_comp, output ready);
endinterface

interface cpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_rad;
  logic [15:0]        magnitude;

  modport source (output valid, output angle_rad, output magnitude, input ready);
  modport sink   (input valid, input angle_rad, input magnitude, output ready);
endinterface

### hdl/cartesian_to_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_converter
// Angle (rational atan2 approximation) and floor magnitude of a vector.
// ----------------------------------------------------------------------------
// Takes one vector per cycle while the output is not stalled and returns its
// angle (radians times 8192) and floor(sqrt(x^2+y^2)). Most of the stages are
// the pipelined restoring dividers: 32 stages for the ratio y/x and 14 for the
// final rational quotient, one quotient bit per stage; the root is found one
// bit per stage alongside the first divider. A stall at the output freezes
// the whole pipeline, and the input is ready whenever the output register
// is empty or being read.
module cartesian_to_polar_converter
  import cpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cpc_in_if.sink     cart,
  cpc_out_if.source  polar
);

  pipe_t              st      [NSTAGES];
  pipe_t              st_next [NSTAGES];
  logic [NSTAGES-1:0] vld;
  logic               en;

  assign en         = !vld[NSTAGES-1] || polar.ready;
  assign cart.ready = en;

  genvar g;
  generate
    for (g = 0; g < NSTAGES; g++) begin : g_stage
      if (g == ST_ABS) begin : g_abs
        always_comb begin
          st_next[g]          = '0;
          st_next[g].xneg     = cart.x_comp[15];
          st_next[g].yneg     = cart.y_comp[15];
          st_next[g].ax       = cart.x_comp[15] ? 16'(~cart.x_comp + 16'd1) : cart.x_comp;
          st_next[g].ay       = cart.y_comp[15] ? 16'(~cart.y_comp + 16'd1) : cart.y_comp;
          st_next[g].xzero    = (cart.x_comp == 16'sd0);
          st_next[g].yzero    = (cart.y_comp == 16'sd0);
          st_next[g].ratio_lt = (st_next[g].ay < st_next[g].ax);
          st_next[g].xx       = 31'(32'(st_next[g].ax) * 32'(st_next[g].ax));
          st_next[g].yy       = 31'(32'(st_next[g].ay) * 32'(st_next[g].ay));
        end
      end else if (g == ST_SUM) begin : g_sum
        always_comb begin
          st_next[g]    = st[g-1];
          st_next[g].sq = 32'(st[g-1].xx) + 32'(st[g-1].yy);
          st_next[g].r1 = {st[g-1].ay, 16'd0};
          st_next[g].q1 = '0;
          st_next[g].rt = '0;
        end
      end else if (g >= ST_DIV1 && g < ST_SQR) begin : g_div1
        localparam int B  = ST_DIV1 + ZQ_BITS - 1 - g;
        localparam int RB = ROOT_BITS - 1 - (g - ST_DIV1);
        logic [47:0]          dsh;
        logic [ROOT_BITS-1:0] t;
        always_comb begin
          st_next[g] = st[g-1];
          dsh = 48'(st[g-1].ax) << B;
          if (48'(st[g-1].r1) >= dsh) begin
            st_next[g].r1    = 32'(48'(st[g-1].r1) - dsh);
            st_next[g].q1[B] = 1'b1;
          end
          // one root bit per stage while bits remain
          t = st[g-1].rt;
          if (RB >= 0) begin
            t = st[g-1].rt | (ROOT_BITS'(1) << ((RB >= 0) ? RB : 0));
            if (64'(t) * 64'(t) <= 64'(st[g-1].sq)) st_next[g].rt = t;
          end
        end
      end else if (g == ST_SQR) begin : g_sqr
        logic [63:0] p;
        always_comb begin
          st_next[g]    = st[g-1];
          p             = 64'(st[g-1].q1) * 64'(st[g-1].q1);
          st_next[g].zz = p[16 +: ZZ_BITS];
        end
      end else if (g == ST_K) begin : g_k
        logic [31:0] p;
        always_comb begin
          st_next[g]   = st[g-1];
          p            = 32'(K028_Q16) * 32'(st[g-1].zz[15:0]);
          st_next[g].k = p[30:16];
        end
      end else if (g == ST_SETUP) begin : g_setup
        always_comb begin
          st_next[g]    = st[g-1];
          st_next[g].r2 = NUM_BITS'({st[g-1].q1, 13'd0});
          st_next[g].d2 = st[g-1].ratio_lt ? ZZ_BITS'(ONE_Q16) + ZZ_BITS'(st[g-1].k)
                                           : st[g-1].zz + ZZ_BITS'(K028_Q16);
          st_next[g].q2 = '0;
        end
      end else if (g >= ST_DIV2 && g < ST_OUT) begin : g_div2
        localparam int B = ST_DIV2 + Q2_BITS - 1 - g;
        logic [60:0] dsh;
        always_comb begin
          st_next[g] = st[g-1];
          dsh = 61'(st[g-1].d2) << B;
          if (61'(st[g-1].r2) >= dsh) begin
            st_next[g].r2    = NUM_BITS'(61'(st[g-1].r2) - dsh);
            st_next[g].q2[B] = 1'b1;
          end
        end
      end else begin : g_out
        logic signed [17:0] a;
        logic signed [17:0] t;
        logic signed [17:0] res;
        logic               same;
        always_comb begin
          st_next[g] = st[g-1];
          a    = 18'(st[g-1].q2);
          same = (st[g-1].xneg == st[g-1].yneg);
          if (st[g-1].xzero) begin
            t   = '0;
            res = st[g-1].yzero ? 18'sd0 :
                  st[g-1].yneg  ? -18'(ANG_HALF_PI) : 18'(ANG_HALF_PI);
          end else if (st[g-1].ratio_lt) begin
            t = (same || st[g-1].yzero) ? a : -a;
            if (!st[g-1].xneg)     res = t;
            else if (st[g-1].yneg) res = t - 18'(ANG_PI);
            else                   res = t + 18'(ANG_PI);
          end else begin
            t   = same ? 18'(ANG_HALF_PI) - a : 18'(ANG_HALF_PI) + a;
            res = st[g-1].yneg ? t - 18'(ANG_PI) : t;
          end
          st_next[g].ang = 16'(res);
          st_next[g].mag = 16'(st[g-1].rt);
        end
      end

      always_ff @(posedge clk) begin
        if (en) st[g] <= st_next[g];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGES-2:0], cart.valid};
    end
  end

  assign polar.valid     = vld[NSTAGES-1];
  assign polar.angle_rad = st[NSTAGES-1].ang;
  assign polar.magnitude = st[NSTAGES-1].mag;

  // zero magnitude only comes from the zero vector
  a_zero_vec : assert property (@(posedge clk) disable iff (rst)
    polar.valid && polar.magnitude == 16'd0 |-> polar.angle_rad == 16'sd0)
    else $error("zero magnitude with nonzero angle");

  a_ang_range : assert property (@(posedge clk) disable iff (rst)
    polar.valid |-> ($signed(polar.angle_rad) >= -16'sd25736 &&
                     $signed(polar.angle_rad) <= 16'sd25736))
    else $error("angle out of range");

  a_enter : assert property (@(posedge clk) disable iff (rst)
    cart.valid && cart.ready |=> vld[0])
    else $error("accepted item lost at pipeline entry");

endmodule

### verif/tb_cartesian_to_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_converter
// Self-checking bench for the cartesian-to-polar converter.
// ----------------------------------------------------------------------------
// Drives signed vectors over the cart channel and checks every polar item
// against an in-bench model of the rational atan2 approximation and the
// floor square root. The stimulus covers axes, diagonals and field extremes,
// then random vectors. Both sides idle in random bursts, the receiver holds
// off long enough to fill the pipeline, and the sender drains midway and at the end.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_converter;
  import cpc_pkg::*;

  typedef struct {
    logic signed [15:0] ang;
    logic [15:0]        mag;
  } polar_t;

  class polar_scoreboard;
    polar_t pending[$];
    int     errors;

    function automatic polar_t predict(logic signed [15:0] x, logic signed [15:0] y);
      polar_t p;
      longint ax, ay, zq, zz, k, a, t, sq, rt, b;
      bit same;
      ax = (x < 0) ? -longint'(x) : longint'(x);
      ay = (y < 0) ? -longint'(y) : longint'(y);
      if (x == 0) begin
        t = (y > 0) ? ANG_HALF_PI : (y == 0) ? 0 : -ANG_HALF_PI;
      end else begin
        same = (x < 0) == (y < 0);
        zq = (ay << 16) / ax;
        zz = (zq * zq) >> 16;
        if (ay < ax) begin
          k = (K028_Q16 * zz) >> 16;
          a = (zq << 13) / (ONE_Q16 + k);
          t = (same || y == 0) ? a : -a;
          if (x < 0) t = (y < 0) ? t - ANG_PI : t + ANG_PI;
        end else begin
          a = (zq << 13) / (zz + K028_Q16);
          t = same ? ANG_HALF_PI - a : ANG_HALF_PI + a;
          if (y < 0) t = t - ANG_PI;
        end
      end
      sq = longint'(x) * x + longint'(y) * y;
      rt = 0;
      for (int i = ROOT_BITS - 1; i >= 0; i--) begin
        b = rt | (longint'(1) << i);
        if (b * b <= sq) rt = b;
      end
      p.ang = t[15:0];
      p.mag = rt[15:0];
      return p;
    endfunction

    function void note_vector(logic signed [15:0] x, logic signed [15:0] y);
      pending.push_back(predict(x, y));
    endfunction

    task check_polar(logic signed [15:0] ang, logic [15:0] mag);
      polar_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 0, ang);
        return;
      end
      e = pending.pop_front();
      if (ang !== e.ang) report("angle_rad", e.ang, ang);
      if (mag !== e.mag) report("magnitude", e.mag, mag);
    endtask

    task report(string what, int exp_v, int got_v);
      errors++;
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    endtask
  endclass

  logic clk;
  logic rst;
  cpc_in_if  cart();
  cpc_out_if polar();

  cartesian_to_polar_converter dut (.clk(clk), .rst(rst), .cart(cart), .polar(polar));

  polar_scoreboard sb;
  bit  no_idle;
  bit  hold_off;
  bit  timed_out;
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // sender
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      cart.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cart.valid  <= 1'b1;
    cart.x_comp <= x;
    cart.y_comp <= y;
    // ready is sampled at the edge itself
    @(posedge clk iff cart.ready);
    sb.note_vector(x, y);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      3: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // receiver
  initial begin
    int gap;
    polar.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        polar.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        gap = $urandom_range(1, 11);
        polar.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        polar.ready <= 1'b1;
      end else begin
        polar.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && polar.valid && polar.ready) sb.check_polar(polar.angle_rad, polar.magnitude);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (cart.valid && cart.ready) || (polar.valid && polar.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 2000 && !timed_out) begin
      timed_out = 1'b1;
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] edge_x[] = '{0, 0, 0, 100, -100, 100, -100, 100, -100, 16'sh7fff,
                                     16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 1, -1,
                                     300, 200, -300, -200, 16'shffff, 5};
    logic signed [15:0] edge_y[] = '{0, 7, -7, 0, 0, 100, 100, -100, -100, 16'sh7fff,
                                     16'sh8000, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 1,
                                     200, 300, -200, 300, 16'shffff, 16'sh8000};
    sb = new();
    rst = 1'b1;
    cart.valid  = 1'b0;
    cart.x_comp = '0;
    cart.y_comp = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_x[i]) send_vector(edge_x[i], edge_y[i]);

    // receiver holds off long enough to back up the whole pipeline
    fork
      begin
        hold_off = 1'b1;
        repeat (NSTAGES * 3) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_vector(rand_comp(), rand_comp());
    join

    // drain completely before continuing
    cart.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < 360; i++) send_vector(rand_comp(), rand_comp());
    no_idle = 1'b1;
    for (int i = 0; i < 120; i++) send_vector(rand_comp(), rand_comp());
    cart.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NSTAGES + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
